// File: rtl/tscc_pkg.sv
// ----------------------------------------------------------------------------
// tscc_pkg
// Types and constants shared by the transport stream continuity checker.
// ----------------------------------------------------------------------------
package tscc_pkg;

    localparam int PID_W     = 13;
    localparam int PID_COUNT = 1 << PID_W;
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_WINDOW = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT  = 4'd1;

    // Input opcodes.
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [7:0]  SYNC_BYTE      = 8'h47;
    localparam logic [9:0]  MIN_PACKET_LEN = 10'd188;
    localparam logic [10:0] ADAPT_HDR_LEN  = 11'd5;
    localparam int          DISC_BIT       = 7;
    localparam logic [19:0] WINDOW_RESET   = 20'd60000;
    localparam logic [31:0] SHOW_MAX       = 32'd511;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic pop;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic expire;
    } t_sts;

endpackage

// File: rtl/tscc_ctl.sv
// ----------------------------------------------------------------------------
// tscc_ctl
// Sequencer: clearing pass, input accept, expiry loop, commit and output valid.
// ----------------------------------------------------------------------------
module tscc_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  tscc_pkg::t_sts i_sts,
    output tscc_pkg::t_cmd o_cmd
);

    tscc_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    // The output register can take a new result when empty or being emptied.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tscc_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tscc_pkg::S_CLEAR: begin
                if (i_sts.clear_done) n_state = tscc_pkg::S_IDLE;
            end
            tscc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tscc_pkg::S_READ;
            end
            tscc_pkg::S_READ: begin
                n_state = tscc_pkg::S_CHECK;
            end
            tscc_pkg::S_CHECK: begin
                // A popped entry moves the head; its new entry is read in S_READ again.
                n_state = i_sts.expire ? tscc_pkg::S_READ : tscc_pkg::S_COMMIT;
            end
            tscc_pkg::S_COMMIT: begin
                if (w_out_free) n_state = tscc_pkg::S_IDLE;
            end
            default: n_state = tscc_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear_wr = (r_state == tscc_pkg::S_CLEAR);
        o_cmd.accept   = (r_state == tscc_pkg::S_IDLE) && i_in_valid;
        o_cmd.pop      = (r_state == tscc_pkg::S_CHECK) && i_sts.expire;
        o_cmd.commit   = (r_state == tscc_pkg::S_COMMIT) && w_out_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != tscc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/tscc_dp.sv
// ----------------------------------------------------------------------------
// tscc_dp
// Datapath: configuration, per-PID counter memory, error time ring and
// result registers.
// ----------------------------------------------------------------------------
module tscc_dp #(
    parameter int ERR_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tscc_pkg::t_cmd                   i_cmd,
    output tscc_pkg::t_sts                   o_sts,
    input  logic                             i_cfg_wr,
    input  logic [tscc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    input  logic                             i_opcode,
    input  logic [31:0]                      i_now_ms,
    input  logic [9:0]                       i_packet_length,
    input  logic [7:0]                       i_sync_byte,
    input  logic [7:0]                       i_pid_high_byte,
    input  logic [7:0]                       i_pid_low_byte,
    input  logic [7:0]                       i_control_byte,
    input  logic [7:0]                       i_adaptation_length,
    input  logic [7:0]                       i_adaptation_flags,
    output logic                             o_header_ok,
    output logic [12:0]                      o_packet_pid,
    output logic [3:0]                       o_packet_counter,
    output logic                             o_discontinuity_seen,
    output logic                             o_cc_error,
    output logic [8:0]                       o_errors_in_window,
    output logic                             o_over_limit
);

    localparam int PW = (ERR_DEPTH > 1) ? $clog2(ERR_DEPTH) : 1;
    localparam int CW = $clog2(ERR_DEPTH + 1);
    localparam int SW = PW + 1;
    localparam int PID_W = tscc_pkg::PID_W;

    // Configuration.
    logic [19:0] r_window;
    logic [12:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= tscc_pkg::WINDOW_RESET;
            r_limit  <= '0;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == tscc_pkg::CFG_ERROR_WINDOW) r_window <= i_cfg_data[19:0];
            if (i_cfg_index == tscc_pkg::CFG_ERROR_LIMIT)  r_limit  <= i_cfg_data[12:0];
        end
    end

    // Captured input item.
    logic        r_opcode;
    logic [31:0] r_now;
    logic [9:0]  r_len;
    logic [7:0]  r_sync, r_b1, r_b2, r_b3, r_afl, r_flags;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_opcode <= i_opcode;
            r_now    <= i_now_ms;
            r_len    <= i_packet_length;
            r_sync   <= i_sync_byte;
            r_b1     <= i_pid_high_byte;
            r_b2     <= i_pid_low_byte;
            r_b3     <= i_control_byte;
            r_afl    <= i_adaptation_length;
            r_flags  <= i_adaptation_flags;
        end
    end

    // Header decode.
    logic             w_ok, w_adapt, w_payload, w_disc;
    logic [PID_W-1:0] w_pid;
    logic [3:0]       w_cc;

    assign w_ok      = (r_opcode == tscc_pkg::OP_PACKET) && (r_len >= tscc_pkg::MIN_PACKET_LEN)
                       && (r_sync == tscc_pkg::SYNC_BYTE);
    assign w_pid     = {r_b1[4:0], r_b2};
    assign w_cc      = r_b3[3:0];
    assign w_adapt   = r_b3[5];
    assign w_payload = r_b3[4];
    assign w_disc    = w_ok && w_adapt && (r_afl != 8'd0)
                       && ({3'b000, r_afl} + tscc_pkg::ADAPT_HDR_LEN <= {1'b0, r_len})
                       && r_flags[tscc_pkg::DISC_BIT];

    // Per-PID memory: {valid, last counter}. Cleared once after reset.
    logic [4:0]       r_pid_mem [tscc_pkg::PID_COUNT];
    logic [4:0]       r_pid_rd;
    logic [PID_W-1:0] r_clr_addr;
    logic             w_pid_we;
    logic [4:0]       w_pid_wdata;
    logic             w_err;

    always_comb begin
        w_pid_we    = 1'b0;
        w_pid_wdata = {1'b1, w_cc};
        w_err       = 1'b0;
        if (w_ok) begin
            if (w_disc) begin
                w_pid_we    = 1'b1;
                w_pid_wdata = {1'b0, w_cc};
            end else if (!r_pid_rd[4]) begin
                w_pid_we = 1'b1;
            end else if (w_payload) begin
                w_pid_we = 1'b1;
                w_err    = (w_cc != r_pid_rd[3:0] + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + PID_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_pid_mem[r_clr_addr] <= '0;
        end else if (i_cmd.commit && w_pid_we) begin
            r_pid_mem[w_pid] <= w_pid_wdata;
        end
        r_pid_rd <= r_pid_mem[w_pid];
    end

    // Error time ring.
    logic [31:0]   r_err_mem [ERR_DEPTH];
    logic [31:0]   r_time_rd;
    logic [PW-1:0] r_head, w_head_inc, w_tail, w_wr_addr;
    logic [CW-1:0] r_count, w_count_after;
    logic [SW-1:0] w_sum;
    logic          w_full;
    logic [31:0]   w_age;

    assign w_full     = (r_count == CW'(ERR_DEPTH));
    assign w_head_inc = (r_head == PW'(ERR_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign w_sum      = SW'(r_head) + SW'(r_count);
    assign w_tail     = (w_sum >= SW'(ERR_DEPTH)) ? PW'(w_sum - SW'(ERR_DEPTH)) : PW'(w_sum);
    assign w_wr_addr  = w_full ? r_head : w_tail;
    assign w_age      = r_now - r_time_rd;

    assign o_sts.expire     = (r_count != '0) && (w_age > 32'(r_window));
    assign o_sts.clear_done = (r_clr_addr == {PID_W{1'b1}});

    assign w_count_after = (w_err && !w_full) ? r_count + CW'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.pop) begin
            r_head  <= w_head_inc;
            r_count <= r_count - CW'(1);
        end else if (i_cmd.commit && w_err) begin
            // A full ring overwrites its oldest entry and moves the head on.
            if (w_full) r_head <= w_head_inc;
            r_count <= w_count_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_err) begin
            r_err_mem[w_wr_addr] <= r_now;
        end
        r_time_rd <= r_err_mem[r_head];
    end

    // Result registers.
    logic [31:0] w_cnt_ext;
    assign w_cnt_ext = 32'(w_count_after);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_header_ok          <= w_ok;
            o_packet_pid         <= w_ok ? w_pid : '0;
            o_packet_counter     <= w_ok ? w_cc : '0;
            o_discontinuity_seen <= w_disc;
            o_cc_error           <= w_err;
            o_errors_in_window   <= (w_cnt_ext > tscc_pkg::SHOW_MAX) ? 9'(tscc_pkg::SHOW_MAX)
                                                                     : w_cnt_ext[8:0];
            o_over_limit         <= (r_limit != '0) && (w_cnt_ext >= 32'(r_limit));
        end
    end

endmodule

// File: rtl/ts_continuity_checker_top.sv
// ----------------------------------------------------------------------------
// ts_continuity_checker_top
// Transport stream continuity counter checker with windowed error count.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 8192-entry PID memory,
// one entry per cycle, and stalls its input until that pass is done;
// configuration writes are taken at any time. Each item then passes through
// accept, memory read, expiry check and commit, and every expired error entry
// dropped from the ring adds another memory read and expiry check, since the
// ring memory is read one entry per pass through its registered read port. A
// new item can be accepted while the previous result waits in the output
// register; the commit waits only while that register is full and stalled.
module ts_continuity_checker_top #(
    parameter int ERR_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tscc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [31:0]                    i_now_ms,
    input  logic [9:0]                     i_packet_length,
    input  logic [7:0]                     i_sync_byte,
    input  logic [7:0]                     i_pid_high_byte,
    input  logic [7:0]                     i_pid_low_byte,
    input  logic [7:0]                     i_control_byte,
    input  logic [7:0]                     i_adaptation_length,
    input  logic [7:0]                     i_adaptation_flags,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_header_ok,
    output logic [12:0]                    o_packet_pid,
    output logic [3:0]                     o_packet_counter,
    output logic                           o_discontinuity_seen,
    output logic                           o_cc_error,
    output logic [8:0]                     o_errors_in_window,
    output logic                           o_over_limit
);

    tscc_pkg::t_cmd w_cmd;
    tscc_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    tscc_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tscc_dp #(
        .ERR_DEPTH (ERR_DEPTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_cfg_wr             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_opcode             (i_opcode),
        .i_now_ms             (i_now_ms),
        .i_packet_length      (i_packet_length),
        .i_sync_byte          (i_sync_byte),
        .i_pid_high_byte      (i_pid_high_byte),
        .i_pid_low_byte       (i_pid_low_byte),
        .i_control_byte       (i_control_byte),
        .i_adaptation_length  (i_adaptation_length),
        .i_adaptation_flags   (i_adaptation_flags),
        .o_header_ok          (o_header_ok),
        .o_packet_pid         (o_packet_pid),
        .o_packet_counter     (o_packet_counter),
        .o_discontinuity_seen (o_discontinuity_seen),
        .o_cc_error           (o_cc_error),
        .o_errors_in_window   (o_errors_in_window),
        .o_over_limit         (o_over_limit)
    );

endmodule

// File: rtl/tscc_checker.sv
// ----------------------------------------------------------------------------
// tscc_checker
// Port-level checks for the continuity checker, bound to the top level.
// ----------------------------------------------------------------------------
module tscc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_header_ok,
    input logic [12:0] o_packet_pid,
    input logic [3:0]  o_packet_counter,
    input logic        o_discontinuity_seen,
    input logic        o_cc_error
);

    // The clearing pass keeps the input stalled right after reset.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A rejected header or a time tick reports no extracted fields.
    a_bad_header_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_header_ok |->
            (o_packet_pid == 13'd0) && (o_packet_counter == 4'd0)
            && !o_discontinuity_seen && !o_cc_error)
        else $error("fields set on a rejected item");

    // A discontinuity resets the PID and never counts as an error.
    a_disc_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_discontinuity_seen |-> o_header_ok && !o_cc_error)
        else $error("error flagged on a discontinuity");

endmodule

bind ts_continuity_checker_top tscc_checker u_tscc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_header_ok          (o_header_ok),
    .o_packet_pid         (o_packet_pid),
    .o_packet_counter     (o_packet_counter),
    .o_discontinuity_seen (o_discontinuity_seen),
    .o_cc_error           (o_cc_error)
);

// File: tb/tscc_checker.sv
// ----------------------------------------------------------------------------
// tscc_scoreboard
// Watches the configuration, packet and status channels of the transport
// stream continuity checker, keeps its own copy of the per-PID counter table
// and of the error time ring, works out the status each accepted transfer
// must produce and compares every status transfer field by field.
// ----------------------------------------------------------------------------
module tscc_scoreboard #(
    parameter int RING_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tscc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_opcode,
    input  logic [31:0]                    i_now_ms,
    input  logic [9:0]                     i_packet_length,
    input  logic [7:0]                     i_sync_byte,
    input  logic [7:0]                     i_pid_high_byte,
    input  logic [7:0]                     i_pid_low_byte,
    input  logic [7:0]                     i_control_byte,
    input  logic [7:0]                     i_adaptation_length,
    input  logic [7:0]                     i_adaptation_flags,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_header_ok,
    input  logic [12:0]                    i_packet_pid,
    input  logic [3:0]                     i_packet_counter,
    input  logic                           i_discontinuity_seen,
    input  logic                           i_cc_error,
    input  logic [8:0]                     i_errors_in_window,
    input  logic                           i_over_limit,
    input  logic                           i_end,
    output int                             o_fail_count
);

    localparam int AWAIT_DEPTH = 8;

    typedef struct packed {
        logic        header_ok;
        logic [12:0] pid;
        logic [3:0]  counter;
        logic        disc;
        logic        cc_error;
        logic [8:0]  held;
        logic        over;
    } t_cc_status;

    bit          pid_seen    [tscc_pkg::PID_COUNT];
    logic [3:0]  pid_last_cc [tscc_pkg::PID_COUNT];
    logic [31:0] err_stamp   [RING_DEPTH];
    int          ring_head;
    int          ring_fill;
    logic [19:0] age_limit;
    logic [12:0] alarm_limit;
    t_cc_status  awaited_status [AWAIT_DEPTH];
    int          await_wr;
    int          await_rd;
    bit          end_checked;

    task automatic note_failure(input string msg);
        $display("[%0t] tscc_scoreboard: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            note_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Works out the status of one header or tick and advances the model state.
    task automatic judge_packet(output t_cc_status st);
        logic [31:0] age;
        logic [1:0]  afc;
        logic [12:0] pid;
        logic [3:0]  cc;
        logic        disc;
        bit          expiring;

        st = '0;
        // Only the oldest entry is tested, so a young head holds back the rest.
        expiring = 1'b1;
        while (expiring && ring_fill > 0) begin
            age = i_now_ms - err_stamp[ring_head];
            if (age > {12'd0, age_limit}) begin
                ring_head = (ring_head + 1) % RING_DEPTH;
                ring_fill--;
            end else begin
                expiring = 1'b0;
            end
        end

        if (i_opcode == tscc_pkg::OP_PACKET && i_packet_length >= tscc_pkg::MIN_PACKET_LEN
                && i_sync_byte == tscc_pkg::SYNC_BYTE) begin
            afc  = i_control_byte[5:4];
            pid  = {i_pid_high_byte[4:0], i_pid_low_byte};
            cc   = i_control_byte[3:0];
            disc = 1'b0;
            if (afc[1] && i_adaptation_length != 8'd0
                    && {3'd0, i_adaptation_length} + tscc_pkg::ADAPT_HDR_LEN
                       <= {1'b0, i_packet_length}) begin
                disc = i_adaptation_flags[tscc_pkg::DISC_BIT];
            end
            st.header_ok = 1'b1;
            st.pid       = pid;
            st.counter   = cc;
            st.disc      = disc;
            if (disc) begin
                pid_seen[pid] = 1'b0;
            end else if (!pid_seen[pid]) begin
                pid_seen[pid]    = 1'b1;
                pid_last_cc[pid] = cc;
            end else if (afc[0]) begin
                if (cc != pid_last_cc[pid] + 4'd1) begin
                    st.cc_error = 1'b1;
                    // A full ring drops its oldest entry for the new one.
                    if (ring_fill >= RING_DEPTH) begin
                        err_stamp[ring_head] = i_now_ms;
                        ring_head = (ring_head + 1) % RING_DEPTH;
                    end else begin
                        err_stamp[(ring_head + ring_fill) % RING_DEPTH] = i_now_ms;
                        ring_fill++;
                    end
                end
                pid_last_cc[pid] = cc;
            end
        end
        st.held = (ring_fill > int'(tscc_pkg::SHOW_MAX)) ? 9'(tscc_pkg::SHOW_MAX)
                                                         : 9'(ring_fill);
        st.over = (alarm_limit != 13'd0) && (ring_fill >= int'(alarm_limit));
    endtask

    always @(posedge i_clk) begin : watch
        t_cc_status got;
        t_cc_status want;

        if (!i_rst_n) begin
            for (int p = 0; p < tscc_pkg::PID_COUNT; p++) begin
                pid_seen[p] = 1'b0;
            end
            ring_head    = 0;
            ring_fill    = 0;
            age_limit    = tscc_pkg::WINDOW_RESET;
            alarm_limit  = 13'd0;
            await_wr     = 0;
            await_rd     = 0;
            end_checked  = 1'b0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tscc_pkg::CFG_ERROR_WINDOW: age_limit   = i_cfg_data[19:0];
                    tscc_pkg::CFG_ERROR_LIMIT:  alarm_limit = i_cfg_data[12:0];
                    default: ;
                endcase
            end

            // A status leaving in this cycle belongs to an older transfer,
            // so it is matched before the new header is judged.
            if (i_out_valid && !i_out_stall) begin
                got = {i_header_ok, i_packet_pid, i_packet_counter, i_discontinuity_seen,
                       i_cc_error, i_errors_in_window, i_over_limit};
                if (await_wr == await_rd) begin
                    note_failure("status transfer with no header waiting for it");
                end else begin
                    want = awaited_status[await_rd % AWAIT_DEPTH];
                    await_rd++;
                    check_field("header_ok", 32'(got.header_ok), 32'(want.header_ok));
                    check_field("packet_pid", 32'(got.pid), 32'(want.pid));
                    check_field("packet_counter", 32'(got.counter), 32'(want.counter));
                    check_field("discontinuity_seen", 32'(got.disc), 32'(want.disc));
                    check_field("cc_error", 32'(got.cc_error), 32'(want.cc_error));
                    check_field("errors_in_window", 32'(got.held), 32'(want.held));
                    check_field("over_limit", 32'(got.over), 32'(want.over));
                end
            end

            if (i_in_valid && !i_in_stall) begin
                judge_packet(want);
                if (await_wr - await_rd >= AWAIT_DEPTH) begin
                    note_failure("too many headers waiting for their status");
                end
                awaited_status[await_wr % AWAIT_DEPTH] = want;
                await_wr++;
            end

            if (i_end && !end_checked) begin
                end_checked = 1'b1;
                if (await_wr != await_rd) begin
                    note_failure($sformatf("%0d status transfers never arrived",
                                           await_wr - await_rd));
                end
            end
        end
    end

endmodule

// File: tb/ts_continuity_checker_top_tb.sv
// ----------------------------------------------------------------------------
// ts_continuity_checker_top_tb
// Drives headers and ticks into the continuity checker: a directed pass over
// bad headers, counter wrap, duplicates, discontinuity bounds, expiry edges and
// wrapping time, then random streams over several window and alarm settings,
// idling at random on both sides but in the last. Checked by tscc_scoreboard.
// ----------------------------------------------------------------------------
module ts_continuity_checker_top_tb;

    localparam int RING_DEPTH        = 256;
    localparam int STALL_HOLD_CYCLES = 60;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tscc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                    i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic                           i_opcode;
    logic [31:0]                    i_now_ms;
    logic [9:0]                     i_packet_length;
    logic [7:0]                     i_sync_byte;
    logic [7:0]                     i_pid_high_byte;
    logic [7:0]                     i_pid_low_byte;
    logic [7:0]                     i_control_byte;
    logic [7:0]                     i_adaptation_length;
    logic [7:0]                     i_adaptation_flags;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic                           o_header_ok;
    logic [12:0]                    o_packet_pid;
    logic [3:0]                     o_packet_counter;
    logic                           o_discontinuity_seen;
    logic                           o_cc_error;
    logic [8:0]                     o_errors_in_window;
    logic                           o_over_limit;

    int          fail_count;
    int          headers_taken;
    int          status_taken;
    logic        stream_done;
    bit          quiet;
    bit          hold_req;
    logic [31:0] stream_ms;
    logic [12:0] pid_pool [8];
    logic [3:0]  next_cc  [8];

    ts_continuity_checker_top #(
        .ERR_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_now_ms            (i_now_ms),
        .i_packet_length     (i_packet_length),
        .i_sync_byte         (i_sync_byte),
        .i_pid_high_byte     (i_pid_high_byte),
        .i_pid_low_byte      (i_pid_low_byte),
        .i_control_byte      (i_control_byte),
        .i_adaptation_length (i_adaptation_length),
        .i_adaptation_flags  (i_adaptation_flags),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_header_ok         (o_header_ok),
        .o_packet_pid        (o_packet_pid),
        .o_packet_counter    (o_packet_counter),
        .o_discontinuity_seen(o_discontinuity_seen),
        .o_cc_error          (o_cc_error),
        .o_errors_in_window  (o_errors_in_window),
        .o_over_limit        (o_over_limit)
    );

    tscc_scoreboard #(
        .RING_DEPTH(RING_DEPTH)
    ) u_scoreboard (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_now_ms            (i_now_ms),
        .i_packet_length     (i_packet_length),
        .i_sync_byte         (i_sync_byte),
        .i_pid_high_byte     (i_pid_high_byte),
        .i_pid_low_byte      (i_pid_low_byte),
        .i_control_byte      (i_control_byte),
        .i_adaptation_length (i_adaptation_length),
        .i_adaptation_flags  (i_adaptation_flags),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_header_ok         (o_header_ok),
        .i_packet_pid        (o_packet_pid),
        .i_packet_counter    (o_packet_counter),
        .i_discontinuity_seen(o_discontinuity_seen),
        .i_cc_error          (o_cc_error),
        .i_errors_in_window  (o_errors_in_window),
        .i_over_limit        (o_over_limit),
        .i_end               (stream_done),
        .o_fail_count        (fail_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            headers_taken <= 0;
            status_taken  <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                headers_taken <= headers_taken + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                status_taken <= status_taken + 1;
            end
        end
    end

    // Status receiver: short random stalls, one long hold-off on request.
    initial begin : receiver
        int burst;

        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (STALL_HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                burst = $urandom_range(1, 3);
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_item(input logic op, input logic [31:0] now, input logic [9:0] len,
                             input logic [7:0] sync, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] afl, input logic [7:0] flags);
        int gap;

        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid          = 1'b1;
        i_opcode            = op;
        i_now_ms            = now;
        i_packet_length     = len;
        i_sync_byte         = sync;
        i_pid_high_byte     = b1;
        i_pid_low_byte      = b2;
        i_control_byte      = b3;
        i_adaptation_length = afl;
        i_adaptation_flags  = flags;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Well-formed header; the spare PID and scrambling bits are random.
    task automatic send_packet(input logic [12:0] pid, input logic [1:0] afc,
                               input logic [3:0] cc, input logic [7:0] afl,
                               input logic [7:0] flags, input logic [9:0] len);
        logic [2:0] pid_spare;
        logic [1:0] ctl_spare;

        pid_spare = 3'($urandom);
        ctl_spare = 2'($urandom);
        send_item(tscc_pkg::OP_PACKET, stream_ms, len, tscc_pkg::SYNC_BYTE,
                  {pid_spare, pid[12:8]}, pid[7:0], {ctl_spare, afc, cc}, afl, flags);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (status_taken == headers_taken);
    endtask

    task automatic write_reg(input logic [tscc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_item(input int err_pct, input int step_max, input bit payload_only,
                               input int jump_pct);
        int         slot;
        int         roll;
        logic [1:0] afc;
        logic [3:0] cc;
        logic [7:0] sync_b;
        logic [7:0] flags;
        logic [9:0] len;

        stream_ms += $urandom_range(0, step_max);
        if ($urandom_range(0, 99) < jump_pct) begin
            stream_ms += $urandom;
        end
        roll = payload_only ? 99 : $urandom_range(0, 99);
        if (roll < 4) begin
            send_item(tscc_pkg::OP_TICK, stream_ms, 10'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
        end else if (roll < 7) begin
            sync_b = 8'($urandom);
            if (sync_b == tscc_pkg::SYNC_BYTE) begin
                sync_b = ~sync_b;
            end
            send_item(tscc_pkg::OP_PACKET, stream_ms, 10'($urandom), sync_b, 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (roll < 9) begin
            send_item(tscc_pkg::OP_PACKET, stream_ms, 10'($urandom_range(0, 187)),
                      tscc_pkg::SYNC_BYTE, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        end else begin
            slot = $urandom_range(0, 7);
            roll = $urandom_range(0, 9);
            if (payload_only || roll < 6) begin
                afc = 2'd1;
            end else if (roll < 8) begin
                afc = 2'd3;
            end else if (roll < 9) begin
                afc = 2'd2;
            end else begin
                afc = 2'd0;
            end
            // An offset of 15 repeats the last counter, which is a duplicate.
            cc = next_cc[slot];
            if ($urandom_range(0, 99) < err_pct) begin
                cc = next_cc[slot] + 4'($urandom_range(1, 15));
            end
            if (afc[0]) begin
                next_cc[slot] = cc + 4'd1;
            end
            len = ($urandom_range(0, 1) != 0) ? tscc_pkg::MIN_PACKET_LEN
                                              : 10'($urandom_range(188, 1023));
            flags = 8'($urandom);
            flags[tscc_pkg::DISC_BIT] = ($urandom_range(0, 4) == 0);
            send_packet(pid_pool[slot], afc, cc, 8'($urandom), flags, len);
        end
    endtask

    task automatic run_phase(input logic [31:0] window, input logic [31:0] limit,
                             input int count, input int err_pct, input int step_max,
                             input bit payload_only, input int jump_pct);
        drain();
        write_reg(tscc_pkg::CFG_ERROR_WINDOW, window);
        write_reg(tscc_pkg::CFG_ERROR_LIMIT, limit);
        for (int n = 0; n < count; n++) begin
            random_item(err_pct, step_max, payload_only, jump_pct);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_index         = tscc_pkg::CFG_ERROR_WINDOW;
        i_cfg_data          = 32'd0;
        i_in_valid          = 1'b0;
        i_opcode            = tscc_pkg::OP_TICK;
        i_now_ms            = 32'd0;
        i_packet_length     = 10'd0;
        i_sync_byte         = 8'd0;
        i_pid_high_byte     = 8'd0;
        i_pid_low_byte      = 8'd0;
        i_control_byte      = 8'd0;
        i_adaptation_length = 8'd0;
        i_adaptation_flags  = 8'd0;
        stream_done         = 1'b0;
        quiet               = 1'b0;
        hold_req            = 1'b0;
        stream_ms           = 32'd0;
        pid_pool[0] = 13'h0000;
        pid_pool[1] = 13'h1FFF;
        for (int s = 0; s < 8; s++) begin
            if (s > 1) begin
                pid_pool[s] = 13'($urandom);
            end
            next_cc[s] = 4'($urandom);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: default window, alarm disabled.
        send_item(tscc_pkg::OP_TICK, stream_ms, 10'h3FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF);
        stream_ms = 32'd1;
        send_packet(13'h1FFF, 2'd1, 4'd15, 8'hFF, 8'hFF, 10'd1023);
        drain();
        write_reg(tscc_pkg::CFG_ERROR_WINDOW, 32'd100);
        write_reg(tscc_pkg::CFG_ERROR_LIMIT, 32'd3);

        stream_ms = 32'd2;
        send_item(tscc_pkg::OP_PACKET, stream_ms, tscc_pkg::MIN_PACKET_LEN, 8'h46, 8'h1F,
                  8'hFF, 8'h10, 8'h00, 8'h00);
        stream_ms = 32'd3;
        send_item(tscc_pkg::OP_PACKET, stream_ms, 10'd187, tscc_pkg::SYNC_BYTE, 8'h1F, 8'hFF,
                  8'h10, 8'h00, 8'h00);
        stream_ms = 32'd4;
        send_packet(13'h1FFF, 2'd1, 4'd0, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);  // wraps
        stream_ms = 32'd5;
        send_packet(13'h1FFF, 2'd1, 4'd0, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);  // duplicate
        stream_ms = 32'd6;
        send_packet(13'h1FFF, 2'd0, 4'd9, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);  // no payload
        stream_ms = 32'd7;
        send_packet(13'h1FFF, 2'd1, 4'd5, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);  // gap
        stream_ms = 32'd8;
        send_packet(13'h0000, 2'd1, 4'd3, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);
        stream_ms = 32'd9;
        // Zero adaptation length: the indicator is not read.
        send_packet(13'h0000, 2'd3, 4'd4, 8'd0, 8'h80, tscc_pkg::MIN_PACKET_LEN);
        stream_ms = 32'd10;
        send_packet(13'h0000, 2'd2, 4'd4, 8'd10, 8'h80, tscc_pkg::MIN_PACKET_LEN);
        stream_ms = 32'd11;
        // Adaptation field ends exactly at the packet end, then one byte past it.
        send_packet(13'h0000, 2'd3, 4'd5, 8'd183, 8'h80, tscc_pkg::MIN_PACKET_LEN);
        stream_ms = 32'd12;
        send_packet(13'h0000, 2'd3, 4'd7, 8'd184, 8'h80, tscc_pkg::MIN_PACKET_LEN);
        stream_ms = 32'd13;
        send_packet(13'h0000, 2'd3, 4'd9, 8'd183, 8'h00, tscc_pkg::MIN_PACKET_LEN);  // alarm
        stream_ms = 32'd14;
        send_packet(13'h0000, 2'd2, 4'd2, 8'd255, 8'h7F, 10'd1023);
        // Ages 102, 100 and 94: only the first is past the window.
        stream_ms = 32'd107;
        send_item(tscc_pkg::OP_TICK, stream_ms, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        stream_ms = 32'd5000;
        send_packet(13'h1FFF, 2'd1, 4'd15, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);
        stream_ms = 32'd5100;
        send_packet(13'h1FFF, 2'd1, 4'd15, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);
        // Time steps back: the young head keeps the newer, now "old", entry.
        stream_ms = 32'd5030;
        send_item(tscc_pkg::OP_TICK, stream_ms, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        stream_ms = 32'd5101;
        send_item(tscc_pkg::OP_TICK, stream_ms, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        stream_ms = 32'hFFFF_FFC0;
        send_packet(13'h1FFF, 2'd1, 4'd15, 8'd0, 8'd0, tscc_pkg::MIN_PACKET_LEN);
        stream_ms = 32'h0000_0020;
        send_item(tscc_pkg::OP_TICK, stream_ms, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        stream_ms = 32'h0000_0025;
        send_item(tscc_pkg::OP_TICK, stream_ms, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

        // Widest window and an error burst long enough to overrun the ring.
        run_phase(32'd600000, 32'd256, 280, 100, 2, 1'b1, 0);

        // Narrowest window with time jumps.
        stream_ms = $urandom;
        run_phase(32'd1, 32'd1, 60, 30, 2, 1'b0, 3);

        // The receiver holds off at the start while headers keep coming.
        drain();
        hold_req = 1'b1;
        run_phase($urandom_range(1000, 500000), 32'd4096, 50, 40, 50, 1'b0, 2);

        quiet = 1'b1;
        run_phase($urandom_range(2, 400), 32'd0, 40, 40, 30, 1'b0, 2);

        drain();
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        stream_done = 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: ts_continuity_checker_top.f
rtl/tscc_pkg.sv
rtl/tscc_ctl.sv
rtl/tscc_dp.sv
rtl/ts_continuity_checker_top.sv
rtl/tscc_checker.sv
tb/tscc_checker.sv
tb/ts_continuity_checker_top_tb.sv
